// ===== src/nst_pkg.sv =====
// Shared types, constants and helpers of the named semaphore table.
`timescale 1ns / 1ps
package nst_pkg;

  localparam int unsigned SLOTS      = 16;
  localparam int unsigned NAME_BYTES = 8;
  localparam int unsigned NAME_W     = NAME_BYTES * 8;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W      = (SLOT_W > 4) ? SLOT_W : 4;

  localparam logic [1:0] ACT_OPEN    = 2'd0;
  localparam logic [1:0] ACT_CLOSE   = 2'd1;
  localparam logic [1:0] ACT_TRYWAIT = 2'd2;
  localparam logic [1:0] ACT_SIGNAL  = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_ARGS    = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd3;
  localparam logic [2:0] ST_AT_MAX      = 3'd4;
  localparam logic [2:0] ST_UNUSED      = 3'd5;

  localparam logic [15:0] COUNT_FULL = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] name_key;
    logic [3:0]  name_length;
    logic        create_enable;
    logic [15:0] initial_count;
    logic [15:0] maximum_count;
    logic [3:0]  slot;
  } nst_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  result_slot;
    logic [15:0] current_value;
  } nst_out_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [NAME_W-1:0] key;
    logic [3:0]        len;
    logic              create;
    logic [15:0]       init;
    logic [15:0]       maxv;
    logic [3:0]        slot;
    logic              done;
    logic [2:0]        status;
    logic [SLOT_W-1:0] idx;
    logic [15:0]       value;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
  } nst_tok_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] idx;
    logic [NAME_W-1:0] key;
    logic [3:0]        len;
    logic [15:0]       init;
    logic [15:0]       maxv;
  } nst_alloc_t;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_WALK = 3'b010,
    FSM_DONE = 3'b100
  } nst_fsm_e;

  function automatic logic [NAME_W-1:0] name_mask(input logic [3:0] len);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int b = 0; b < int'(NAME_BYTES); b++) begin
      if (b < int'(len)) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/nst_cell.sv =====
// One slot of the semaphore table: holds its state and passes the request token on.
`timescale 1ns / 1ps
module nst_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [nst_pkg::SLOT_W-1:0]   idx_i,
  input  logic                         tok_valid_i,
  input  nst_pkg::nst_tok_t            tok_i,
  input  nst_pkg::nst_alloc_t          alloc_i,
  output logic                         tok_valid_o,
  output nst_pkg::nst_tok_t            tok_o
);

  logic [15:0]                 ref_q, ref_d;
  logic [15:0]                 val_q, val_d;
  logic [15:0]                 lim_q, lim_d;
  logic [nst_pkg::NAME_W-1:0]  name_q, name_d;
  logic [3:0]                  nlen_q, nlen_d;
  logic                        vld_q;
  nst_pkg::nst_tok_t           tok_q, tok_d;
  logic                        hit_slot;
  logic                        in_use;

  assign in_use   = (ref_q != 16'd0);
  assign hit_slot = (nst_pkg::CMP_W'(tok_i.slot) == nst_pkg::CMP_W'(idx_i));

  always_comb begin
    tok_d  = tok_i;
    ref_d  = ref_q;
    val_d  = val_q;
    lim_d  = lim_q;
    name_d = name_q;
    nlen_d = nlen_q;
    if (tok_valid_i && !tok_i.done) begin
      case (tok_i.action)
        nst_pkg::ACT_OPEN: begin
          if (in_use && nlen_q == tok_i.len && name_q == tok_i.key) begin
            if (ref_q != nst_pkg::COUNT_FULL) begin
              ref_d = ref_q + 16'd1;
            end
            tok_d.done   = 1'b1;
            tok_d.status = nst_pkg::ST_OK;
            tok_d.idx    = idx_i;
            tok_d.value  = val_q;
          end else if (!in_use && !tok_i.free_found) begin
            tok_d.free_found = 1'b1;
            tok_d.free_idx   = idx_i;
          end
        end
        nst_pkg::ACT_CLOSE: begin
          if (hit_slot) begin
            tok_d.done = 1'b1;
            if (!in_use) begin
              tok_d.status = nst_pkg::ST_UNUSED;
              tok_d.value  = 16'd0;
            end else begin
              ref_d        = ref_q - 16'd1;
              tok_d.status = nst_pkg::ST_OK;
              tok_d.value  = val_q;
            end
          end
        end
        nst_pkg::ACT_TRYWAIT: begin
          if (hit_slot) begin
            tok_d.done = 1'b1;
            if (!in_use) begin
              tok_d.status = nst_pkg::ST_UNUSED;
              tok_d.value  = 16'd0;
            end else if (val_q != 16'd0) begin
              val_d        = val_q - 16'd1;
              tok_d.status = nst_pkg::ST_OK;
              tok_d.value  = val_q - 16'd1;
            end else begin
              tok_d.status = nst_pkg::ST_WOULD_BLOCK;
              tok_d.value  = val_q;
            end
          end
        end
        default: begin
          if (hit_slot) begin
            tok_d.done = 1'b1;
            if (!in_use) begin
              tok_d.status = nst_pkg::ST_UNUSED;
              tok_d.value  = 16'd0;
            end else if (val_q >= lim_q) begin
              tok_d.status = nst_pkg::ST_AT_MAX;
              tok_d.value  = val_q;
            end else begin
              val_d        = val_q + 16'd1;
              tok_d.status = nst_pkg::ST_OK;
              tok_d.value  = val_q + 16'd1;
            end
          end
        end
      endcase
    end
    if (alloc_i.valid && alloc_i.idx == idx_i) begin
      ref_d  = 16'd1;
      val_d  = alloc_i.init;
      lim_d  = alloc_i.maxv;
      name_d = alloc_i.key;
      nlen_d = alloc_i.len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= '0;
      val_q  <= '0;
      lim_q  <= '0;
      name_q <= '0;
      nlen_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      ref_q  <= ref_d;
      val_q  <= val_d;
      lim_q  <= lim_d;
      name_q <= name_d;
      nlen_q <= nlen_d;
      vld_q  <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = vld_q;
  assign tok_o       = tok_q;

endmodule

// ===== src/named_semaphore_table.sv =====
// Top level of the named semaphore table: request launch, cell chain and result register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o  | nst_pkg::nst_in_t
//   out     | output    | out_valid_o / out_stall_i| nst_pkg::nst_out_t
//
// Every transaction walks the row of SLOTS cells, one cell per cycle, from the launch
// register through the cells into the finish register and then the result register;
// the next transaction is taken only once its result is loaded into the result register.
// Reset clears all slots at once; the block takes a transaction in the first cycle after.
// A result waiting under out_stall_i holds the finished walk until the register frees.
`timescale 1ns / 1ps
module named_semaphore_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nst_pkg::nst_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nst_pkg::nst_out_t  out_data_o
);

  nst_pkg::nst_fsm_e    state_q, state_d;
  logic                 launch_vld_q;
  nst_pkg::nst_tok_t    launch_q, launch_d;
  nst_pkg::nst_tok_t    fin_q;
  logic                 out_valid_q;
  nst_pkg::nst_out_t    out_q, res;
  nst_pkg::nst_alloc_t  alloc;
  logic                 accept;
  logic                 load;
  logic                 bad;
  logic [nst_pkg::SLOTS:0] chain_vld;
  nst_pkg::nst_tok_t    chain_tok [nst_pkg::SLOTS+1];

  assign accept = in_valid_i && (state_q == nst_pkg::FSM_IDLE);
  assign load   = (state_q == nst_pkg::FSM_DONE) && (!out_valid_q || !out_stall_i);

  assign bad = (in_data_i.action == nst_pkg::ACT_OPEN) &&
               (in_data_i.name_length == 4'd0 ||
                32'(in_data_i.name_length) > nst_pkg::NAME_BYTES ||
                in_data_i.initial_count > in_data_i.maximum_count);

  always_comb begin
    launch_d.action     = in_data_i.action;
    launch_d.key        = nst_pkg::NAME_W'(in_data_i.name_key) &
                          nst_pkg::name_mask(in_data_i.name_length);
    launch_d.len        = in_data_i.name_length;
    launch_d.create     = in_data_i.create_enable;
    launch_d.init       = in_data_i.initial_count;
    launch_d.maxv       = in_data_i.maximum_count;
    launch_d.slot       = in_data_i.slot;
    launch_d.done       = bad;
    launch_d.status     = bad ? nst_pkg::ST_BAD_ARGS : nst_pkg::ST_UNUSED;
    launch_d.idx        = '0;
    launch_d.value      = 16'd0;
    launch_d.free_found = 1'b0;
    launch_d.free_idx   = '0;
  end

  assign chain_vld[0] = launch_vld_q;
  assign chain_tok[0] = launch_q;

  for (genvar i = 0; i < nst_pkg::SLOTS; i++) begin : g_cell
    nst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (nst_pkg::SLOT_W'(i)),
      .tok_valid_i(chain_vld[i]),
      .tok_i      (chain_tok[i]),
      .alloc_i    (alloc),
      .tok_valid_o(chain_vld[i+1]),
      .tok_o      (chain_tok[i+1])
    );
  end

  always_comb begin
    alloc.valid = 1'b0;
    alloc.idx   = fin_q.free_idx;
    alloc.key   = fin_q.key;
    alloc.len   = fin_q.len;
    alloc.init  = fin_q.init;
    alloc.maxv  = fin_q.maxv;
    if (fin_q.done) begin
      res.status        = fin_q.status;
      res.result_slot   = (fin_q.action == nst_pkg::ACT_OPEN) ? 4'(fin_q.idx) : fin_q.slot;
      res.current_value = fin_q.value;
    end else if (fin_q.action == nst_pkg::ACT_OPEN) begin
      if (fin_q.create && fin_q.free_found) begin
        alloc.valid       = load;
        res.status        = nst_pkg::ST_OK;
        res.result_slot   = 4'(fin_q.free_idx);
        res.current_value = fin_q.init;
      end else begin
        res.status        = nst_pkg::ST_NOT_FOUND;
        res.result_slot   = 4'd0;
        res.current_value = 16'd0;
      end
    end else begin
      res.status        = nst_pkg::ST_UNUSED;
      res.result_slot   = fin_q.slot;
      res.current_value = 16'd0;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      nst_pkg::FSM_IDLE: if (accept) state_d = nst_pkg::FSM_WALK;
      nst_pkg::FSM_WALK: if (chain_vld[nst_pkg::SLOTS]) state_d = nst_pkg::FSM_DONE;
      nst_pkg::FSM_DONE: if (load) state_d = nst_pkg::FSM_IDLE;
      default:           state_d = nst_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nst_pkg::FSM_IDLE;
      launch_vld_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      launch_vld_q <= accept;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_q <= launch_d;
    end
    if (chain_vld[nst_pkg::SLOTS]) begin
      fin_q <= chain_tok[nst_pkg::SLOTS];
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign in_stall_o  = (state_q != nst_pkg::FSM_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(chain_vld))
    else $error("more than one token in the cell chain");

  a_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> chain_vld[0] && state_q == nst_pkg::FSM_WALK)
    else $error("accepted transaction not launched");

  a_chain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_vld[nst_pkg::SLOTS] |-> state_q == nst_pkg::FSM_WALK)
    else $error("token left the chain outside a walk");

  a_alloc_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc.valid |-> fin_q.action == nst_pkg::ACT_OPEN && !fin_q.done && load)
    else $error("slot allocated outside an unmatched open");

endmodule
